// File: rtl/glrl_pkg.sv
// Shared types, field widths and codes of the grey list rate limiter.
// Used by glrl_table and grey_list_rate_limiter; depends on nothing.
package glrl_pkg;

	localparam int GLRL_ENTRIES = 64;

	localparam int KEY_W  = 32;
	localparam int ALW_W  = 16;
	localparam int WIN_W  = 24;
	localparam int CNT_W  = 17;
	localparam int TIME_W = 32;

	// request kinds
	localparam logic [1:0] REQ_QUERY  = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// result status codes
	localparam logic [2:0] RES_NOT_FOUND = 3'd0;
	localparam logic [2:0] RES_ALLOW     = 3'd1;
	localparam logic [2:0] RES_DENY      = 3'd2;
	localparam logic [2:0] RES_DONE      = 3'd3;
	localparam logic [2:0] RES_FAILED    = 3'd4;

	// register index (paddr word select)
	localparam logic REG_LIST_ENABLE = 1'b0;

	// access count saturates here
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// one table word
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [ALW_W-1:0]  allowed;
		logic [WIN_W-1:0]  window;
		logic [CNT_W-1:0]  count;
		logic [TIME_W-1:0] start;
	} entry_t;

	// table port strobes
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} tbl_ctl_t;

endpackage

// File: rtl/glrl_table.sv
// Entry table of the grey list: one synchronous memory, one read and one write port,
// with key match and free-slot flags on the registered read word. Depends on glrl_pkg.
module glrl_table
	import glrl_pkg::*;
#(
	parameter int ENTRIES = GLRL_ENTRIES,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  tbl_ctl_t         ctl,
	input  logic [AW-1:0]    rd_addr,
	input  logic [AW-1:0]    wr_addr,
	input  entry_t           wr_data,
	input  logic [KEY_W-1:0] cmp_key,
	output entry_t           rd_data,
	output logic             rd_match,
	output logic             rd_free
);

	entry_t mem_q [ENTRIES];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered read word
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// compare on the returned word
	assign rd_data  = rd_data_q;
	assign rd_match = rd_data_q.valid && (rd_data_q.key == cmp_key);
	assign rd_free  = !rd_data_q.valid;

endmodule

// File: rtl/grey_list_rate_limiter.sv
// Top level of the grey list rate limiter: stream request/result channels, APB register,
// scan/modify/write sequencer around the entry table. Depends on glrl_pkg, glrl_table.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser: req_type; tdata: key, count, allowed, ...
//  m_axis    out  m_axis_tvalid/tready      tdata: status, report_allowed, report_interval
//  apb       in   psel/penable/pready       paddr, pwdata, prdata: list_enable
//
// An enabled request scans the table through its single read port, one entry a cycle,
// ending early on a key hit, then evaluates and, where needed, writes one entry;
// disabled or unused requests skip the scan and go straight to the result stage.
// After reset a sweep over every entry clears the valid bits; no word is accepted then.
// The result register holds one word while the next request is accepted and worked;
// a finished request waits for that register to free up before the next one is taken.
module grey_list_rate_limiter
	import glrl_pkg::*;
#(
	parameter int ENTRIES = GLRL_ENTRIES
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_axis_tdata, low bit up: key[31:0], count_access[32], new_allowed[48:33],
	// new_interval[72:49], now_seconds[104:73], zero pad[111:105]
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,
	// s_axis_tuser: req_type[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// m_axis_tdata, low bit up: status[2:0], report_allowed[18:3],
	// report_interval[42:19], zero pad[47:43]
	output logic [47:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;
	localparam logic [2:0] ST_RESP  = 3'd5;

	logic [2:0] state_q;
	logic       list_enable_q;

	// request word
	logic [1:0]        req_q;
	logic [KEY_W-1:0]  key_q;
	logic              count_q;
	logic [ALW_W-1:0]  nal_q;
	logic [WIN_W-1:0]  niv_q;
	logic [TIME_W-1:0] now_q;

	// scan state
	logic [AW-1:0] rd_addr_q;
	logic          issued_all_q;
	logic          pend_s1;
	logic [AW-1:0] addr_s1;
	logic          hit_q;
	logic [AW-1:0] slot_q;
	logic          free_found_q;
	logic [AW-1:0] free_slot_q;
	entry_t        hit_entry_q;
	logic          expired_q;

	// result staging and output register
	logic [2:0]       res_status_q;
	logic [ALW_W-1:0] res_allowed_q;
	logic [WIN_W-1:0] res_interval_q;
	logic             out_valid_q;
	logic [2:0]       out_status_q;
	logic [ALW_W-1:0] out_allowed_q;
	logic [WIN_W-1:0] out_interval_q;

	// table port
	tbl_ctl_t      tbl_ctl;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	entry_t        rd_data;
	logic          rd_match;
	logic          rd_free;

	// exec results
	logic [2:0]       ex_status;
	logic [ALW_W-1:0] ex_allowed;
	logic [WIN_W-1:0] ex_interval;
	logic             ex_wr;
	logic [AW-1:0]    ex_addr;
	entry_t           ex_data;
	logic [CNT_W-1:0] cnt_base;
	logic [CNT_W-1:0] cnt_new;

	logic             in_acc;
	logic             resp_load;
	logic             cfg_wr;
	logic [TIME_W-1:0] elapsed;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign resp_load     = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

	// APB register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LIST_ENABLE);
	assign prdata = (paddr[2] == REG_LIST_ENABLE) ? {31'b0, list_enable_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			list_enable_q <= pwdata[0];
		end
	end

	glrl_table #(
		.ENTRIES(ENTRIES)
	) u_table (
		.clk     (clk),
		.ctl     (tbl_ctl),
		.rd_addr (rd_addr_q),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.cmp_key (key_q),
		.rd_data (rd_data),
		.rd_match(rd_match),
		.rd_free (rd_free)
	);

	// entry update for the found or free slot
	always_comb begin
		ex_status   = RES_FAILED;
		ex_allowed  = '0;
		ex_interval = '0;
		ex_wr       = 1'b0;
		ex_addr     = slot_q;
		ex_data     = hit_entry_q;
		cnt_base    = expired_q ? '0 : hit_entry_q.count;
		cnt_new     = (count_q && (cnt_base != COUNT_MAX)) ? cnt_base + CNT_W'(1) : cnt_base;
		case (req_q)
			REQ_QUERY: begin
				if (!hit_q) begin
					ex_status = RES_NOT_FOUND;
				end else if (hit_entry_q.allowed == '0) begin
					ex_status = RES_DENY;
				end else if (hit_entry_q.window == '0) begin
					ex_status  = RES_ALLOW;
					ex_allowed = ALW_W'(1);
				end else begin
					ex_allowed  = hit_entry_q.allowed;
					ex_interval = hit_entry_q.window;
					if (expired_q && !count_q) begin
						ex_status = RES_ALLOW;
					end else begin
						ex_status = (cnt_new <= {1'b0, hit_entry_q.allowed}) ? RES_ALLOW : RES_DENY;
						ex_wr         = count_q;
						ex_data.count = cnt_new;
						if (expired_q) begin
							ex_data.start = now_q;
						end
					end
				end
			end
			REQ_ADD: begin
				if (hit_q) begin
					ex_status       = RES_DONE;
					ex_wr           = 1'b1;
					ex_data.allowed = nal_q;
					ex_data.window  = niv_q;
				end else if (free_found_q) begin
					ex_status = RES_DONE;
					ex_wr     = 1'b1;
					ex_addr   = free_slot_q;
					ex_data   = '{valid: 1'b1, key: key_q, allowed: nal_q, window: niv_q,
						count: '0, start: now_q};
				end
			end
			REQ_REMOVE: begin
				ex_status = RES_DONE;
				if (hit_q) begin
					ex_wr         = 1'b1;
					ex_data.valid = 1'b0;
				end
			end
			default: begin
				ex_status = RES_FAILED;
			end
		endcase
	end

	// table port selection: sweep after reset, else exec write
	always_comb begin
		tbl_ctl.rd_en = (state_q == ST_SCAN) && !issued_all_q;
		if (state_q == ST_CLEAR) begin
			tbl_ctl.wr_en = 1'b1;
			wr_addr       = rd_addr_q;
			wr_data       = '0;
		end else begin
			tbl_ctl.wr_en = (state_q == ST_EXEC) && ex_wr;
			wr_addr       = ex_addr;
			wr_data       = ex_data;
		end
	end

	assign elapsed = now_q - hit_entry_q.start;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			rd_addr_q    <= '0;
			issued_all_q <= 1'b0;
			pend_s1      <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			pend_s1 <= tbl_ctl.rd_en;
			case (state_q)
				ST_CLEAR: begin
					rd_addr_q <= rd_addr_q + AW'(1);
					if (rd_addr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						rd_addr_q    <= '0;
						issued_all_q <= 1'b0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						if (list_enable_q && (s_axis_tuser == REQ_QUERY ||
							s_axis_tuser == REQ_ADD || s_axis_tuser == REQ_REMOVE)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SCAN: begin
					if (tbl_ctl.rd_en) begin
						rd_addr_q <= rd_addr_q + AW'(1);
						if (rd_addr_q == LAST) begin
							issued_all_q <= 1'b1;
						end
					end
					if (pend_s1) begin
						if (rd_match) begin
							hit_q   <= 1'b1;
							state_q <= ST_EVAL;
						end else begin
							if (rd_free && !free_found_q) begin
								free_found_q <= 1'b1;
							end
							if (addr_s1 == LAST) begin
								state_q <= ST_EVAL;
							end
						end
					end
				end
				ST_EVAL: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (resp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr_q;
		if (in_acc) begin
			req_q   <= s_axis_tuser;
			key_q   <= s_axis_tdata[31:0];
			count_q <= s_axis_tdata[32];
			nal_q   <= s_axis_tdata[48:33];
			niv_q   <= s_axis_tdata[72:49];
			now_q   <= s_axis_tdata[104:73];
			// short answers when disabled or unused kind
			res_allowed_q  <= '0;
			res_interval_q <= '0;
			case (s_axis_tuser)
				REQ_QUERY:  res_status_q <= RES_NOT_FOUND;
				REQ_REMOVE: res_status_q <= RES_DONE;
				default:    res_status_q <= RES_FAILED;
			endcase
		end
		if (state_q == ST_SCAN && pend_s1) begin
			if (rd_match) begin
				slot_q      <= addr_s1;
				hit_entry_q <= rd_data;
			end else if (rd_free && !free_found_q) begin
				free_slot_q <= addr_s1;
			end
		end
		if (state_q == ST_EVAL) begin
			expired_q <= elapsed > {{(TIME_W-WIN_W){1'b0}}, hit_entry_q.window};
		end
		if (state_q == ST_EXEC) begin
			res_status_q   <= ex_status;
			res_allowed_q  <= ex_allowed;
			res_interval_q <= ex_interval;
		end
		if (resp_load) begin
			out_status_q   <= res_status_q;
			out_allowed_q  <= res_allowed_q;
			out_interval_q <= res_interval_q;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_interval_q, out_allowed_q, out_status_q};

	// checks
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("request taken while another is in flight");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !tbl_ctl.wr_en)
		else $error("table written during scan");

	a_resp_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && out_valid_q && !m_axis_tready) |=> (state_q == ST_RESP))
		else $error("result overwrote a pending word");

endmodule

// File: sim/grey_list_rate_limiter_tb.sv
// Self-checking testbench of grey_list_rate_limiter: stream requests, APB enable register,
// and a shadow copy of the entry table that predicts every result word. Depends on glrl_pkg, grey_list_rate_limiter.
module grey_list_rate_limiter_tb;
	import glrl_pkg::*;

	localparam logic [1:0] REQ_UNUSED      = 2'd3;
	localparam logic [2:0] ADDR_LIST_ENABLE = {REG_LIST_ENABLE, 2'b00};
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int POOL_SIZE      = 80;
	localparam int DRAIN_PAUSE    = GLRL_ENTRIES + 8;

	typedef struct packed {
		logic [1:0]        kind;
		logic [KEY_W-1:0]  key;
		logic              count_access;
		logic [ALW_W-1:0]  allowed;
		logic [WIN_W-1:0]  window;
		logic [TIME_W-1:0] now;
	} request_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [ALW_W-1:0] rep_allowed;
		logic [WIN_W-1:0] rep_window;
	} verdict_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// key[31:0], count_access[32], new_allowed[48:33], new_interval[72:49],
	// now_seconds[104:73], zero pad[111:105]
	logic [111:0] s_axis_tdata;
	// req_type[1:0]
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// status[2:0], report_allowed[18:3], report_interval[42:19], zero pad[47:43]
	logic [47:0]  m_axis_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// shadow of the entry table and of the enable register
	logic              list_on;
	logic              tbl_valid   [GLRL_ENTRIES];
	logic [KEY_W-1:0]  tbl_key     [GLRL_ENTRIES];
	logic [ALW_W-1:0]  tbl_allowed [GLRL_ENTRIES];
	logic [WIN_W-1:0]  tbl_window  [GLRL_ENTRIES];
	logic [CNT_W-1:0]  tbl_count   [GLRL_ENTRIES];
	logic [TIME_W-1:0] tbl_start   [GLRL_ENTRIES];

	verdict_t          verdict_q[$];
	logic [KEY_W-1:0]  key_pool[POOL_SIZE];
	logic [TIME_W-1:0] clock_now;
	int                error_count;
	int                quiet_cycles = 0;
	int                receiver_hold_cycles;
	int                receiver_stall_left;
	bit                sender_gaps_on;
	bit                receiver_stalls_on;

	grey_list_rate_limiter #(
		.ENTRIES(GLRL_ENTRIES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// work out the result word of one request and update the shadow table
	function automatic verdict_t predict_verdict(request_t r);
		verdict_t v;
		int hit;
		int spare;
		logic [TIME_W-1:0] elapsed;
		v.status = RES_FAILED;
		v.rep_allowed = '0;
		v.rep_window = '0;
		hit = -1;
		spare = -1;
		for (int i = GLRL_ENTRIES - 1; i >= 0; i--) begin
			if (tbl_valid[i] && tbl_key[i] == r.key)
				hit = i;
			if (!tbl_valid[i])
				spare = i;
		end
		case (r.kind)
			REQ_QUERY: begin
				if (!list_on || hit < 0)
					v.status = RES_NOT_FOUND;
				else if (tbl_allowed[hit] == '0)
					v.status = RES_DENY;
				else if (tbl_window[hit] == '0) begin
					v.status = RES_ALLOW;
					v.rep_allowed = 16'd1;
				end else begin
					v.rep_allowed = tbl_allowed[hit];
					v.rep_window = tbl_window[hit];
					elapsed = r.now - tbl_start[hit];
					if (elapsed > {8'b0, tbl_window[hit]} && !r.count_access)
						v.status = RES_ALLOW;
					else begin
						// expired window restarts on a counted access
						if (elapsed > {8'b0, tbl_window[hit]}) begin
							tbl_start[hit] = r.now;
							tbl_count[hit] = '0;
						end
						if (r.count_access && tbl_count[hit] != COUNT_MAX)
							tbl_count[hit] = tbl_count[hit] + 1'b1;
						v.status = (tbl_count[hit] <= {1'b0, tbl_allowed[hit]}) ?
							RES_ALLOW : RES_DENY;
					end
				end
			end
			REQ_ADD: begin
				if (list_on && hit >= 0) begin
					// update keeps count and window start
					tbl_allowed[hit] = r.allowed;
					tbl_window[hit] = r.window;
					v.status = RES_DONE;
				end else if (list_on && spare >= 0) begin
					tbl_valid[spare] = 1'b1;
					tbl_key[spare] = r.key;
					tbl_allowed[spare] = r.allowed;
					tbl_window[spare] = r.window;
					tbl_count[spare] = '0;
					tbl_start[spare] = r.now;
					v.status = RES_DONE;
				end
			end
			REQ_REMOVE: begin
				if (list_on && hit >= 0)
					tbl_valid[hit] = 1'b0;
				v.status = RES_DONE;
			end
			default: v.status = RES_FAILED;
		endcase
		return v;
	endfunction

	function automatic request_t make_req(logic [1:0] kind, logic [KEY_W-1:0] key,
		logic count_access, logic [ALW_W-1:0] allowed, logic [WIN_W-1:0] window,
		logic [TIME_W-1:0] now);
		request_t r;
		r.kind = kind;
		r.key = key;
		r.count_access = count_access;
		r.allowed = allowed;
		r.window = window;
		r.now = now;
		return r;
	endfunction

	task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
		error_count++;
		$display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
	endtask

	// send one request word; entered and left at a falling edge
	task automatic send_word(request_t r);
		if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.kind;
		s_axis_tdata <= {7'b0, r.now, r.window, r.allowed, r.count_access, r.key};
		do @(posedge clk); while (!s_axis_tready);
		verdict_q.push_back(predict_verdict(r));
		@(negedge clk);
	endtask

	// stop offering and let every expected word come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic set_list_enable(logic on);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_LIST_ENABLE;
		pwdata <= {31'b0, on};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		list_on = on;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// remove every key the shadow holds so new adds land from slot 0 up
	task automatic flush_table();
		logic [KEY_W-1:0] held[$];
		for (int i = 0; i < GLRL_ENTRIES; i++)
			if (tbl_valid[i])
				held.push_back(tbl_key[i]);
		foreach (held[i])
			send_word(make_req(REQ_REMOVE, held[i], 1'b0, '0, '0, clock_now));
	endtask

	task automatic test_disabled_list();
		set_list_enable(1'b0);
		send_word(make_req(REQ_ADD, 32'h0000_1111, 1'b1, 16'd3, 24'd9, clock_now));
		send_word(make_req(REQ_QUERY, 32'h0000_1111, 1'b1, '0, '0, clock_now));
		send_word(make_req(REQ_REMOVE, 32'h0000_1111, 1'b0, '0, '0, clock_now));
		send_word(make_req(REQ_UNUSED, 32'h0000_1111, 1'b1, '1, '1, clock_now));
	endtask

	task automatic test_directed_cases();
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] t1;
		t0 = 32'hFFFF_FFF0;
		t1 = t0 + 32'h0100_0000;
		set_list_enable(1'b1);
		// deny-all entry, allow-all entry
		send_word(make_req(REQ_ADD, 32'h0000_0000, 1'b0, 16'd0, 24'd5, t0));
		send_word(make_req(REQ_QUERY, 32'h0000_0000, 1'b1, '0, '0, t0));
		send_word(make_req(REQ_ADD, 32'hFFFF_FFFF, 1'b0, 16'd1, 24'd0, t0));
		send_word(make_req(REQ_QUERY, 32'hFFFF_FFFF, 1'b1, '0, '0, t0));
		// limit of two per widest window, then expiry across the time wrap
		send_word(make_req(REQ_ADD, 32'hA5A5_5A5A, 1'b0, 16'd2, 24'hFF_FFFF, t0));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b1, '0, '0, t0));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b1, '0, '0, t0));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b1, '0, '0, t0));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b0, '0, '0, t0));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b0, '0, '0, t1));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b1, '0, '0, t1));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b1, '0, '0, t1 + 32'hFF_FFFF));
		// update keeps count and start
		send_word(make_req(REQ_ADD, 32'hA5A5_5A5A, 1'b1, 16'hFFFF, 24'd1, t0));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b1, '0, '0, t1 + 1));
		send_word(make_req(REQ_REMOVE, 32'hA5A5_5A5A, 1'b0, '0, '0, t1));
		send_word(make_req(REQ_REMOVE, 32'hA5A5_5A5A, 1'b0, '0, '0, t1));
		send_word(make_req(REQ_QUERY, 32'hA5A5_5A5A, 1'b1, '0, '0, t1));
		send_word(make_req(REQ_UNUSED, 32'h5A5A_A5A5, 1'b0, '0, '0, t1));
		send_word(make_req(REQ_ADD, 32'h1234_5678, 1'b0, 16'hFFFF, 24'hFF_FFFF, t1));
		send_word(make_req(REQ_QUERY, 32'h1234_5678, 1'b1, '0, '0, t1 + 5));
	endtask

	task automatic test_table_full();
		flush_table();
		for (int i = 0; i < GLRL_ENTRIES; i++)
			send_word(make_req(REQ_ADD, 32'hC0DE_0000 + i, 1'b0, 16'($urandom_range(0, 4)),
				24'($urandom_range(0, 9)), clock_now));
		send_word(make_req(REQ_ADD, 32'hC0DE_F00D, 1'b0, 16'd4, 24'd9, clock_now));
		send_word(make_req(REQ_QUERY, 32'hC0DE_F00D, 1'b1, '0, '0, clock_now));
		send_word(make_req(REQ_REMOVE, 32'hC0DE_000A, 1'b0, '0, '0, clock_now));
		send_word(make_req(REQ_ADD, 32'hC0DE_F00D, 1'b0, 16'd4, 24'd9, clock_now));
		send_word(make_req(REQ_QUERY, 32'hC0DE_F00D, 1'b1, '0, '0, clock_now));
	endtask

	task automatic test_random_traffic(int n_items);
		request_t r;
		int pick;
		for (int n = 0; n < n_items; n++) begin
			pick = $urandom_range(0, 99);
			r.kind = (pick < 55) ? REQ_QUERY : (pick < 80) ? REQ_ADD :
				(pick < 95) ? REQ_REMOVE : REQ_UNUSED;
			// stray keys only for lookups, so the table stays reachable
			if (r.kind != REQ_ADD && $urandom_range(0, 9) == 0)
				r.key = $urandom;
			else
				r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			r.count_access = ($urandom_range(0, 3) != 0);
			r.allowed = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 6));
			r.window = ($urandom_range(0, 4) == 0) ? 24'($urandom) :
				24'($urandom_range(0, 12));
			if ($urandom_range(0, 49) == 0)
				clock_now = $urandom;
			else
				clock_now = clock_now + $urandom_range(0, 2);
			r.now = clock_now;
			send_word(r);
		end
	endtask

	// long receiver hold-off fills the block, then the sender waits it out
	task automatic test_backpressure();
		receiver_hold_cycles = 400;
		for (int n = 0; n < 16; n++)
			send_word(make_req(REQ_QUERY, key_pool[$urandom_range(0, POOL_SIZE - 1)],
				1'b1, '0, '0, clock_now));
		wait_drained();
		test_random_traffic(60);
		wait_drained();
	endtask

	// receiver: random stall bursts plus requested hold-offs
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_hold_cycles > 0) begin
				receiver_hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (receiver_stall_left > 0) begin
				receiver_stall_left--;
				m_axis_tready <= 1'b0;
			end else if (receiver_stalls_on && $urandom_range(0, 7) == 0) begin
				receiver_stall_left = $urandom_range(0, 14);
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[2:0];
			got.rep_allowed = m_axis_tdata[18:3];
			got.rep_window = m_axis_tdata[42:19];
			if (verdict_q.size() == 0)
				log_mismatch("unexpected word, status", '0, 32'(got.status));
			else begin
				want = verdict_q.pop_front();
				if (got.status !== want.status)
					log_mismatch("status", 32'(want.status), 32'(got.status));
				if (got.rep_allowed !== want.rep_allowed)
					log_mismatch("report_allowed", 32'(want.rep_allowed),
						32'(got.rep_allowed));
				if (got.rep_window !== want.rep_window)
					log_mismatch("report_interval", 32'(want.rep_window),
						32'(got.rep_window));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("** grey_list_rate_limiter: FAILED **");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= REQ_QUERY;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		list_on = 1'b0;
		error_count = 0;
		receiver_hold_cycles = 0;
		receiver_stall_left = 0;
		sender_gaps_on = 1'b0;
		receiver_stalls_on = 1'b0;
		clock_now = $urandom;
		for (int i = 0; i < GLRL_ENTRIES; i++)
			tbl_valid[i] = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_disabled_list();
		test_directed_cases();
		test_table_full();

		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
		test_random_traffic(800);
		test_backpressure();
		set_list_enable(1'b0);
		test_random_traffic(150);
		set_list_enable(1'b1);
		test_random_traffic(450);

		// closing stretch at full rate
		sender_gaps_on = 1'b0;
		receiver_stalls_on = 1'b0;
		test_random_traffic(400);
		wait_drained();

		if (error_count == 0)
			$display("** grey_list_rate_limiter: PASSED **");
		else
			$display("** grey_list_rate_limiter: FAILED **");
		$finish;
	end

endmodule
